>>> rtl/iva_pkg.sv
// Shared types and constants of the interval moving average unit.
// Depends on nothing; imported by every other file of the block.
`timescale 1ns / 1ps

package iva_pkg;

    localparam int TS_W              = 32;      // timestamp and interval width
    localparam int WS_W              = 7;       // window size register width
    localparam int CNT_OUT_W         = 7;       // held count output width
    localparam int DEF_WINDOW_DEPTH  = 64;      // default store depth
    localparam logic [WS_W-1:0] WINDOW_SIZE_RST = 7'd8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FRONT,
        S_PRE_RD,
        S_PRE_SUB,
        S_WRITE,
        S_CHK,
        S_DRP_RD,
        S_DRP_SUB,
        S_DIV_START,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;      // latch the incoming timestamp
        logic arm;          // first event: arm tracker, record time
        logic take_ivl;     // later event: form interval, record time
        logic rd_oldest;    // read the oldest store entry
        logic drop;         // remove the oldest entry from the window
        logic write;        // append the interval to the window
        logic div_start;    // start the mean division
        logic load_out;     // load the result word into the output register
    } t_cmd;

    typedef struct packed {
        logic running;
        logic full;
        logic over_limit;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

>>> rtl/interval_moving_average_unit.sv
// Top level of the interval moving average unit.
// Depends on iva_pkg, iva_ctrl and iva_datapath (which holds iva_divider).
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                 Word
//  ------    ---------  ------------------------  --------------------------------
//  input     in         i_in_valid / o_in_ready   i_timestamp_ms
//  output    out        o_out_valid / i_out_ready o_average_ms, o_held_count,
//                                                 o_armed_only
//  config    in         i_cfg_wr_en               i_cfg_wr_data (window size)
//
//  Flow: an interval word passes the store and then the bit-serial mean divider,
//  with a read and a drop for each interval dropped from the window and a read and
//  a drop before the append when the store is full; the input is ready again in the
//  cycle after the result is loaded. The divider takes the SUM_W-bit running sum,
//  SUM_W = 32 + clog2(WINDOW_DEPTH+1); arming words skip the store, not the divider.
//  Reset: synchronous, active low; the input is not ready while reset is held. The
//  interval store is not cleared, only entries already written are ever read.
//  Stalls: a result word waits in the output register while the next input
//  word is taken; the controller only holds at its end if that register is full.

module interval_moving_average_unit #(
    parameter int WINDOW_DEPTH = iva_pkg::DEF_WINDOW_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [iva_pkg::WS_W-1:0]      i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [iva_pkg::TS_W-1:0]      i_timestamp_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [iva_pkg::TS_W-1:0]      o_average_ms,
    output logic [iva_pkg::CNT_OUT_W-1:0] o_held_count,
    output logic                          o_armed_only
);
    import iva_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequence each word: arm or form interval, make room, append, trim, divide
    iva_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // hold the window, the running sum and the output register
    iva_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_timestamp_ms (i_timestamp_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_average_ms   (o_average_ms),
        .o_held_count   (o_held_count),
        .o_armed_only   (o_armed_only)
    );

endmodule

>>> rtl/iva_ctrl.sv
// Controller state machine of the interval moving average unit.
// Depends on iva_pkg; drives the datapath by t_cmd and reads t_status.
`timescale 1ns / 1ps

module iva_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  iva_pkg::t_status i_status,
    output iva_pkg::t_cmd    o_cmd
);
    import iva_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // refuse words while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_FRONT;
                end
            end
            S_FRONT: begin
                if (!i_status.running) begin
                    o_cmd.arm = 1'b1;
                    n_state   = S_DIV_START;
                end else begin
                    o_cmd.take_ivl = 1'b1;
                    n_state        = i_status.full ? S_PRE_RD : S_WRITE;
                end
            end
            S_PRE_RD: begin
                o_cmd.rd_oldest = 1'b1;
                n_state         = S_PRE_SUB;
            end
            S_PRE_SUB: begin
                o_cmd.drop = 1'b1;
                n_state    = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_CHK;
            end
            S_CHK: begin
                n_state = i_status.over_limit ? S_DRP_RD : S_DIV_START;
            end
            S_DRP_RD: begin
                o_cmd.rd_oldest = 1'b1;
                n_state         = S_DRP_SUB;
            end
            S_DRP_SUB: begin
                o_cmd.drop = 1'b1;
                n_state    = S_CHK;
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the previous word has left the output register
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/iva_divider.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on iva_pkg for the quotient width; used by iva_datapath.
`timescale 1ns / 1ps

module iva_divider #(
    parameter int DIVIDEND_W = 39,
    parameter int DIVISOR_W  = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [DIVIDEND_W-1:0]   i_dividend,
    input  logic [DIVISOR_W-1:0]    i_divisor,
    output logic                    o_done,
    output logic [iva_pkg::TS_W-1:0] o_quotient
);
    import iva_pkg::*;

    localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  r_busy;
    logic [STEP_W-1:0]     r_step;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic                  r_zero;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_next;
    logic                  fits;

    always_comb begin
        rem_shift = {r_rem, r_quo[DIVIDEND_W-1]};
        fits      = rem_shift >= {1'b0, r_div};
        rem_next  = fits ? (rem_shift - {1'b0, r_div}) : rem_shift;
    end

    assign o_done     = r_busy && (r_step == STEP_W'(DIVIDEND_W - 1));
    assign o_quotient = r_zero ? '0 : r_quo[TS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_zero <= (i_divisor == '0);
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
            r_rem <= rem_next[DIVISOR_W-1:0];
        end
    end

endmodule

>>> rtl/iva_datapath.sv
// Datapath: window register, interval store, running sum and output word.
// Depends on iva_pkg and iva_divider; steered by iva_ctrl commands.
`timescale 1ns / 1ps

module iva_datapath #(
    parameter int WINDOW_DEPTH = iva_pkg::DEF_WINDOW_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  iva_pkg::t_cmd                 i_cmd,
    output iva_pkg::t_status              o_status,
    input  logic                          i_cfg_wr_en,
    input  logic [iva_pkg::WS_W-1:0]      i_cfg_wr_data,
    input  logic [iva_pkg::TS_W-1:0]      i_timestamp_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [iva_pkg::TS_W-1:0]      o_average_ms,
    output logic [iva_pkg::CNT_OUT_W-1:0] o_held_count,
    output logic                          o_armed_only
);
    import iva_pkg::*;

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = TS_W + CNT_W;
    localparam int CMP_W = (CNT_W > WS_W) ? CNT_W : WS_W;

    logic [TS_W-1:0]      mem [0:WINDOW_DEPTH-1];
    logic [TS_W-1:0]      r_rdata;

    logic                 r_running;
    logic [TS_W-1:0]      r_last;
    logic [TS_W-1:0]      r_now;
    logic [TS_W-1:0]      r_interval;
    logic [IDX_W-1:0]     r_oldest;
    logic [CNT_W-1:0]     r_count;
    logic [SUM_W-1:0]     r_sum;
    logic [WS_W-1:0]      r_ws;
    logic                 r_armed;

    logic                 r_out_valid;
    logic [TS_W-1:0]      r_avg;
    logic [CNT_OUT_W-1:0] r_held;
    logic                 r_out_armed;

    logic [CMP_W-1:0]     ws_ext;
    logic [CMP_W-1:0]     limit;
    logic [CMP_W-1:0]     count_ext;
    logic [IDX_W:0]       wr_pos;
    logic [IDX_W-1:0]     wr_slot;
    logic [IDX_W-1:0]     oldest_next;
    logic                 div_done;
    logic [TS_W-1:0]      quotient;

    always_comb begin
        ws_ext    = CMP_W'(r_ws);
        limit     = (ws_ext > CMP_W'(WINDOW_DEPTH)) ? CMP_W'(WINDOW_DEPTH) : ws_ext;
        count_ext = CMP_W'(r_count);
        wr_pos    = (IDX_W+1)'(r_oldest) + (IDX_W+1)'(r_count);
        wr_slot   = (wr_pos >= (IDX_W+1)'(WINDOW_DEPTH))
                    ? IDX_W'(wr_pos - (IDX_W+1)'(WINDOW_DEPTH)) : wr_pos[IDX_W-1:0];
        oldest_next = (r_oldest == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : r_oldest + 1'b1;
    end

    always_comb begin
        o_status.running    = r_running;
        o_status.full       = (r_count == CNT_W'(WINDOW_DEPTH));
        o_status.over_limit = (count_ext > limit);
        o_status.div_done   = div_done;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    // interval store: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem[wr_slot] <= r_interval;
        end
        if (i_cmd.rd_oldest) begin
            r_rdata <= mem[r_oldest];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws      <= WINDOW_SIZE_RST;
            r_running <= 1'b0;
            r_last    <= '0;
            r_oldest  <= '0;
            r_count   <= '0;
            r_sum     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ws <= i_cfg_wr_data;
            end
            if (i_cmd.arm) begin
                r_running <= 1'b1;
                r_last    <= r_now;
            end
            if (i_cmd.take_ivl) begin
                r_last <= r_now;
            end
            if (i_cmd.drop) begin
                r_sum    <= r_sum - SUM_W'(r_rdata);
                r_oldest <= oldest_next;
                r_count  <= r_count - 1'b1;
            end
            if (i_cmd.write) begin
                r_sum   <= r_sum + SUM_W'(r_interval);
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now <= i_timestamp_ms;
        end
        if (i_cmd.arm) begin
            r_armed <= 1'b1;
        end
        if (i_cmd.take_ivl) begin
            r_armed    <= 1'b0;
            r_interval <= r_now - r_last;
        end
    end

    iva_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_avg       <= quotient;
            r_held      <= count_ext[CNT_OUT_W-1:0];
            r_out_armed <= r_armed;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_average_ms = r_avg;
    assign o_held_count = r_held;
    assign o_armed_only = r_out_armed;

endmodule
